// ----- rtl/core/bpdc_pkg.sv -----
package bpdc_pkg;

  // fixed field widths
  localparam int LEVEL_BITS = 4;
  localparam int CFG_W      = 16;
  localparam int HINT_W     = 9;
  localparam int IDX_W      = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PRESS_MIN   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SHORT_MAX   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MID_MAX     = 2'd2;
  localparam logic [IDX_W-1:0] REG_HINT_LENGTH = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0]  PRESS_MIN_RST   = 16'd5;
  localparam logic [CFG_W-1:0]  SHORT_MAX_RST   = 16'd300;
  localparam logic [CFG_W-1:0]  MID_MAX_RST     = 16'd500;
  localparam logic [HINT_W-1:0] HINT_LENGTH_RST = 9'd300;

  // blink timing
  localparam logic [6:0] BLINK_LAST = 7'd99;  // period 100
  localparam logic [6:0] BLINK_ON   = 7'd20;
  localparam logic [2:0] FAST_LAST  = 3'd5;   // 2 x 3 - 1
  localparam logic [2:0] FAST_DIV   = 3'd3;
  localparam logic [5:0] SLOW_LAST  = 6'd59;  // 2 x 30 - 1
  localparam logic [5:0] SLOW_DIV   = 6'd30;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_MID   = 2'd2,
    CLS_LONG  = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    HINT_OFF  = 2'd0,
    HINT_SLOW = 2'd1,
    HINT_FAST = 2'd2
  } hint_t;

  typedef enum logic [1:0] {
    POL_DOING = 2'd0,
    POL_NEXT  = 2'd1,
    POL_LAST  = 2'd2
  } policy_t;

  localparam logic [1:0] EVT_NONE = 2'd0;
  localparam logic [1:0] EVT_NEXT = 2'd1;
  localparam logic [1:0] EVT_LAST = 2'd2;

  // what a lane reports to the merge stage
  typedef struct packed {
    logic nz;    // hold count nonzero after this tick's increment
    logic inc;   // hold count steps up
    logic clr;   // classified release, count clears
    cls_t cls;   // class of this tick's release
  } lane_stat_t;

  // merge stage result
  typedef struct packed {
    logic       led;
    logic       aux;
    logic [1:0] event_code;
    policy_t    policy;
    hint_t      hint;
  } merge_out_t;

endpackage

// ----- rtl/core/bpdc_if.sv -----
interface bpdc_tick_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [bpdc_pkg::LEVEL_BITS-1:0]  button_levels;

  modport source (output valid, mode, button_levels, input ready);
  modport sink   (input valid, mode, button_levels, output ready);
endinterface

interface bpdc_result_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic       aux_pin;
  logic [1:0] button1_class;
  logic [1:0] button2_class;
  logic [1:0] button3_class;
  logic [1:0] policy_event;
  logic [1:0] run_policy;
  logic [1:0] hint_mode;

  modport source (output valid, led_on, aux_pin, button1_class, button2_class,
                  button3_class, policy_event, run_policy, hint_mode,
                  input ready);
  modport sink   (input valid, led_on, aux_pin, button1_class, button2_class,
                  button3_class, policy_event, run_policy, hint_mode,
                  output ready);
endinterface

// ----- rtl/core/button_press_duration_classifier.sv -----
// channel  dir  handshake      payload
// tick     in   valid / ready  mode, button_levels
// result   out  valid / ready  led_on, aux_pin, button1..3_class, policy_event,
//                              run_policy, hint_mode
// wr       in   wr_en only     wr_index, wr_data (no read-back)
//
// one tick transaction per cycle unless stalled; its result shows in the output
// register in the cycle after acceptance, all state updates in that same cycle
// rst is synchronous, active high; ready is low while rst is high
// a result waiting in the output register does not block ticks as long as the
// sink takes it in the same cycle; only a stalled full register holds off ticks
module button_press_duration_classifier #(
  parameter int BUTTONS    = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  bpdc_tick_if.sink                  tick,
  bpdc_result_if.source              result,
  input  logic                       wr_en,
  input  logic [bpdc_pkg::IDX_W-1:0] wr_index,
  input  logic [bpdc_pkg::CFG_W-1:0] wr_data
);
  import bpdc_pkg::*;

  // only four button levels exist on the tick, so lanes beyond that never matter
  localparam int LANES = (BUTTONS < LEVEL_BITS) ? BUTTONS : LEVEL_BITS;

  // configuration registers
  logic [CFG_W-1:0]  press_min;
  logic [CFG_W-1:0]  short_max;
  logic [CFG_W-1:0]  mid_max;
  logic [HINT_W-1:0] hint_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_min   <= PRESS_MIN_RST;
      short_max   <= SHORT_MAX_RST;
      mid_max     <= MID_MAX_RST;
      hint_length <= HINT_LENGTH_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_PRESS_MIN:   press_min   <= wr_data;
        REG_SHORT_MAX:   short_max   <= wr_data;
        REG_MID_MAX:     mid_max     <= wr_data;
        REG_HINT_LENGTH: hint_length <= wr_data[HINT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the output register frees up when the sink takes it
  logic accept;
  logic scan;
  logic hint_tick;

  assign tick.ready = !rst && (!result.valid || result.ready);
  assign accept     = tick.valid && tick.ready;
  assign scan       = accept && !tick.mode;
  assign hint_tick  = accept && tick.mode;

  // one lane per button: hold counter and release classifier
  lane_stat_t stat     [LANES];
  cls_t       cls_next [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bpdc_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .scan      (scan),
      .level     (tick.button_levels[i]),
      .press_min (press_min),
      .short_max (short_max),
      .mid_max   (mid_max),
      .stat      (stat[i]),
      .cls_next  (cls_next[i])
    );
  end

  // merge: button 0 drives led blink, policy and hint
  merge_out_t res;

  bpdc_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .scan        (scan),
    .hint_tick   (hint_tick),
    .s0          (stat[0]),
    .hint_length (hint_length),
    .res         (res)
  );

  // latched classes of buttons 1 to 3, none for buttons that do not exist
  cls_t cls_out [1:3];

  for (genvar j = 1; j <= 3; j++) begin : g_cls
    if (j < LANES) begin : g_on
      assign cls_out[j] = cls_next[j];
    end else begin : g_off
      assign cls_out[j] = CLS_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.led_on        <= res.led;
      result.aux_pin       <= res.aux;
      result.button1_class <= cls_out[1];
      result.button2_class <= cls_out[2];
      result.button3_class <= cls_out[3];
      result.policy_event  <= res.event_code;
      result.run_policy    <= res.policy;
      result.hint_mode     <= res.hint;
    end
  end

endmodule

// ----- rtl/core/bpdc_lane.sv -----
module bpdc_lane #(
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       scan,
  input  logic                       level,
  input  logic [bpdc_pkg::CFG_W-1:0] press_min,
  input  logic [bpdc_pkg::CFG_W-1:0] short_max,
  input  logic [bpdc_pkg::CFG_W-1:0] mid_max,
  output bpdc_pkg::lane_stat_t       stat,
  output bpdc_pkg::cls_t             cls_next
);
  import bpdc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CMP_W-1:0]      cnt_x;
  cls_t                  cls;
  cls_t                  cls_now;
  logic                  pressed;
  logic                  released;
  logic                  sat;

  assign pressed   = scan && !level;
  assign released  = scan && level;
  assign sat       = &count;
  assign count_inc = (pressed && !sat) ? count + 1'b1 : count;
  assign cnt_x     = CMP_W'(count);

  // release classification, thresholds checked in order
  always_comb begin
    if (!released || cnt_x <= CMP_W'(press_min)) begin
      cls_now = CLS_NONE;
    end else if (cnt_x <= CMP_W'(short_max)) begin
      cls_now = CLS_SHORT;
    end else if (cnt_x <= CMP_W'(mid_max)) begin
      cls_now = CLS_MID;
    end else begin
      cls_now = CLS_LONG;
    end
  end

  assign stat.nz  = |count_inc;
  assign stat.inc = pressed && !sat;
  assign stat.clr = (cls_now != CLS_NONE);
  assign stat.cls = cls_now;
  assign cls_next = (cls_now != CLS_NONE) ? cls_now : cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cls   <= CLS_NONE;
    end else if (scan) begin
      count <= stat.clr ? '0 : count_inc;
      cls   <= cls_next;
    end
  end

endmodule

// ----- rtl/core/bpdc_merge.sv -----
module bpdc_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        scan,
  input  logic                        hint_tick,
  input  bpdc_pkg::lane_stat_t        s0,
  input  logic [bpdc_pkg::HINT_W-1:0] hint_length,
  output bpdc_pkg::merge_out_t        res
);
  import bpdc_pkg::*;

  logic              led;
  logic              aux;
  policy_t           policy;
  hint_t             hint;
  logic [HINT_W-1:0] hint_count;
  logic [2:0]        m6;     // hint_count mod 6
  logic [5:0]        m60;    // hint_count mod 60
  logic [6:0]        m100;   // button 0 hold count mod 100

  logic [HINT_W:0]   next_cnt;
  logic [2:0]        m6_next;
  logic [5:0]        m60_next;
  logic [6:0]        m100_cur;
  logic              phase;
  logic              hint_end;

  assign m100_cur = s0.inc ? ((m100 == BLINK_LAST) ? '0 : m100 + 1'b1) : m100;
  assign next_cnt = {1'b0, hint_count} + 1'b1;
  assign m6_next  = (m6 == FAST_LAST) ? '0 : m6 + 1'b1;
  assign m60_next = (m60 == SLOW_LAST) ? '0 : m60 + 1'b1;
  assign phase    = (hint == HINT_FAST) ? (m6_next >= FAST_DIV) : (m60_next >= SLOW_DIV);
  assign hint_end = next_cnt > {1'b0, hint_length};

  always_comb begin
    res.led        = led;
    res.aux        = aux;
    res.event_code = EVT_NONE;
    res.policy     = policy;
    res.hint       = hint;
    if (scan) begin
      res.led = s0.nz && (m100_cur < BLINK_ON);
      case (s0.cls)
        CLS_SHORT: begin
          res.policy     = POL_NEXT;
          res.hint       = HINT_SLOW;
          res.event_code = EVT_NEXT;
        end
        CLS_MID, CLS_LONG: begin
          res.policy     = POL_LAST;
          res.hint       = HINT_FAST;
          res.event_code = EVT_LAST;
        end
        default: ;
      endcase
    end else if (hint_tick) begin
      if (hint == HINT_SLOW || hint == HINT_FAST) begin
        res.led = phase;
        res.aux = !phase;
        if (hint_end) res.hint = HINT_OFF;
      end else begin
        res.led = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led        <= 1'b0;
      aux        <= 1'b0;
      policy     <= POL_DOING;
      hint       <= HINT_OFF;
      hint_count <= '0;
      m6         <= '0;
      m60        <= '0;
      m100       <= '0;
    end else begin
      if (scan || hint_tick) begin
        led    <= res.led;
        aux    <= res.aux;
        policy <= res.policy;
        hint   <= res.hint;
      end
      if (scan) begin
        m100 <= s0.clr ? '0 : m100_cur;
      end
      if (hint_tick && (hint == HINT_SLOW || hint == HINT_FAST)) begin
        if (hint_end) begin
          hint_count <= '0;
          m6         <= '0;
          m60        <= '0;
        end else begin
          hint_count <= next_cnt[HINT_W-1:0];
          m6         <= m6_next;
          m60        <= m60_next;
        end
      end
    end
  end

endmodule

// ----- rtl/core/bpdc_checker.sv -----
module bpdc_checker (
  input logic       clk,
  input logic       rst,
  input logic       tick_valid,
  input logic       tick_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] policy_event,
  input logic [1:0] run_policy,
  input logic [1:0] hint_mode,
  input logic [1:0] b1,
  input logic       led_on
);
  import bpdc_pkg::*;

  // stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(policy_event) && $stable(run_policy) &&
      $stable(hint_mode) && $stable(b1) && $stable(led_on))
    else $error("result payload changed while stalled");

  // every accepted tick yields a result next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> res_valid)
    else $error("accepted tick gave no result");

  // empty output register never blocks ticks
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> tick_ready)
    else $error("tick stalled with empty output register");

  // a policy selection sets the policy and the matching hint speed
  a_event_policy: assert property (@(posedge clk) disable iff (rst)
    res_valid && policy_event != EVT_NONE |->
      run_policy == policy_event && hint_mode == policy_event)
    else $error("policy event disagrees with policy or hint");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .policy_event (result.policy_event),
  .run_policy   (result.run_policy),
  .hint_mode    (result.hint_mode),
  .b1           (result.button1_class),
  .led_on       (result.led_on)
);
